/* hdl/jmc_pkg.sv */
// ----------------------------------------------------------------------------
// jmc_pkg
// Shared widths, codes and constants of the joint move controller.
// ----------------------------------------------------------------------------
package jmc_pkg;

    // field widths
    localparam int ANGLE_W     = 32;
    localparam int MS_W        = 16;
    localparam int GAIN_W      = 24;
    localparam int FRAC_W      = 16;
    localparam int LIMIT_W     = 31;
    localparam int PHASE_W     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    // internal widths
    localparam int DIST_W    = ANGLE_W + 1;        // exact angle difference
    localparam int DVD_W     = 42;                 // |delta| * 1000 fits below 2^42
    localparam int SPD_W     = DVD_W;              // speed magnitude
    localparam int MUL_A_W   = 44;                 // largest magnitude operand
    localparam int MUL_B_W   = GAIN_W;             // gain operand
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int Q_FRAC    = 16;                 // fraction bits of Q16.16
    localparam int Q_W       = MUL_P_W - Q_FRAC;
    localparam int ERR_W     = MUL_A_W;

    typedef logic [PHASE_W-1:0]   phase_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // move phases
    localparam phase_t PH_DRIVE   = 2'd0;
    localparam phase_t PH_ARRIVED = 2'd1;
    localparam phase_t PH_DONE    = 2'd2;

    // item kinds
    localparam logic CMD_TARGET = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // register indexes
    localparam cfg_idx_t REG_SPEED_GAIN   = 3'd0;
    localparam cfg_idx_t REG_ACCEL_GAIN   = 3'd1;
    localparam cfg_idx_t REG_ARRIVAL_FRAC = 3'd2;
    localparam cfg_idx_t REG_MAX_SPEED    = 3'd3;
    localparam cfg_idx_t REG_MIN_ARRIVAL  = 3'd4;

    // register reset values
    localparam logic [GAIN_W-1:0]  RST_SPEED_GAIN   = 24'd65536;
    localparam logic [GAIN_W-1:0]  RST_ACCEL_GAIN   = 24'd65536;
    localparam logic [FRAC_W-1:0]  RST_ARRIVAL_FRAC = 16'd6554;
    localparam logic [LIMIT_W-1:0] RST_MAX_SPEED    = 31'd1310720;
    localparam logic [LIMIT_W-1:0] RST_MIN_ARRIVAL  = 31'd6554;

    // output saturation bounds
    localparam logic [ANGLE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ANGLE_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

/* hdl/jmc_mul.sv */
// ----------------------------------------------------------------------------
// jmc_mul
// Serial shift-add multiplier, one bit of the B operand per cycle.
// ----------------------------------------------------------------------------
module jmc_mul #(
    parameter int A_W = 44,
    parameter int B_W = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start_i,
    input  logic [A_W-1:0]     a_i,
    input  logic [B_W-1:0]     b_i,
    output logic               done_o,
    output logic [A_W+B_W-1:0] prod_o
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [A_W-1:0]     a_reg, a_next;
    logic [B_W-1:0]     b_reg, b_next;
    logic [A_W+B_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [A_W:0]       sum;

    // add the operand into the upper half, then shift the product right
    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sum       = {1'b0, acc_reg[A_W+B_W-1:B_W]} + (b_reg[0] ? {1'b0, a_reg} : '0);
        if (start_i) begin
            a_next    = a_i;
            b_next    = b_i;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = {sum, acc_reg[B_W-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done_o = done_reg;
    assign prod_o = acc_reg;

endmodule

/* hdl/jmc_div.sv */
// ----------------------------------------------------------------------------
// jmc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jmc_div #(
    parameter int DVD_W = 42,
    parameter int DVS_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_i,
    input  logic [DVD_W-1:0] dividend_i,
    input  logic [DVS_W-1:0] divisor_i,
    output logic             done_o,
    output logic [DVD_W-1:0] quot_o
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    // shift in the next dividend bit and subtract where it fits
    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start_i) begin
            q_next    = dividend_i;
            rem_next  = '0;
            dvs_next  = divisor_i;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done_o = done_reg;
    assign quot_o = q_reg;

endmodule

/* hdl/joint_move_controller_unit.sv */
// ----------------------------------------------------------------------------
// joint_move_controller_unit
// Cascaded proportional position and speed controller for one joint.
// ----------------------------------------------------------------------------
// A set-target item (tuser 0) is taken and gives no result. A sample item
// (tuser 1) gives one result, which waits while the result side holds off.
// The first sample of a move runs the arrival product through the serial
// multiplier; a later sample with nonzero elapsed time first divides the
// angle change times 1000 by the elapsed time in the 42-step serial divider.
// A sample that stays in drive then runs the target speed and acceleration
// products, one in arrived only the acceleration product, and one that ends
// in done neither. The slowest case is a later sample in drive, the quickest
// a done sample with zero elapsed time. One sample is in flight at a time;
// the next item is taken as soon as the result sits in the output register.
// Configuration writes are taken at any time and must only come while no
// sample is in flight.
module joint_move_controller_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample and target items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [jmc_pkg::IN_TDATA_W-1:0]     s_tdata,   // angle[31:0], elapsed_ms[47:32]
    input  logic                               s_tuser,   // cmd
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [jmc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // accel_out[31:0], phase[33:32]
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [jmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import jmc_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ARR   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_PHASE = 3'd3;
    localparam logic [2:0] ST_TSPD  = 3'd4;
    localparam logic [2:0] ST_ERR   = 3'd5;
    localparam logic [2:0] ST_ACC   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // configuration
    logic [GAIN_W-1:0]  speed_gain_reg, speed_gain_next;
    logic [GAIN_W-1:0]  accel_gain_reg, accel_gain_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [LIMIT_W-1:0] max_speed_reg, max_speed_next;
    logic [LIMIT_W-1:0] min_arr_reg, min_arr_next;

    // move state
    logic [ANGLE_W-1:0] target_reg, target_next;
    logic [ANGLE_W-1:0] prev_reg, prev_next;
    logic [ANGLE_W-1:0] arr_reg, arr_next;
    logic               dir_reg, dir_next;
    phase_t             phase_reg, phase_next;
    logic               first_reg, first_next;

    // per-sample working values
    logic [2:0]         state_reg, state_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [DIST_W-1:0]  dmag_reg, dmag_next;
    logic               dneg_reg, dneg_next;
    logic [MS_W-1:0]    ms_reg, ms_next;
    logic [SPD_W-1:0]   spd_mag_reg, spd_mag_next;
    logic               spd_neg_reg, spd_neg_next;
    logic [ANGLE_W-1:0] tspd_reg, tspd_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [ANGLE_W-1:0] acc_reg, acc_next;
    logic               mul_start_reg, mul_start_next;
    logic               div_start_reg, div_start_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [ANGLE_W-1:0] m_accel_reg, m_accel_next;
    phase_t             m_phase_reg, m_phase_next;

    // datapath signals
    logic [ANGLE_W-1:0] in_angle;
    logic [MS_W-1:0]    in_ms;
    logic [DIST_W-1:0]  dist_in;
    logic [DIST_W-1:0]  delta_in;
    logic [DIST_W-1:0]  dist_mag;
    logic [DVD_W-1:0]   dmag_ext;
    logic [DVD_W-1:0]   dividend;
    logic [ERR_W-1:0]   err_mag;
    logic [ERR_W-1:0]   tspd_ext;
    logic [ERR_W-1:0]   spd_ext;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    logic               mul_done;
    logic [SPD_W-1:0]   div_quot;
    logic               div_done;
    logic [Q_W-1:0]     prod_q;
    logic [LIMIT_W-1:0] arr_sat;
    logic               arr_pos;
    logic [LIMIT_W-1:0] ts_clip;
    logic               crossed;
    logic               big_pos;
    logic               big_neg;
    logic               in_fire;
    logic               out_free;

    // input fields
    assign in_angle = s_tdata[ANGLE_W-1:0];
    assign in_ms    = s_tdata[ANGLE_W +: MS_W];
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // angle differences, kept exact at one bit wider
    assign dist_in  = {target_reg[ANGLE_W-1], target_reg} - {in_angle[ANGLE_W-1], in_angle};
    assign delta_in = {in_angle[ANGLE_W-1], in_angle} - {prev_reg[ANGLE_W-1], prev_reg};
    assign dist_mag = dist_reg[DIST_W-1] ? (~dist_reg + 1'b1) : dist_reg;

    // |delta| * 1000 as 1024 - 16 - 8 times |delta|
    assign dmag_ext = {{(DVD_W-DIST_W){1'b0}}, dmag_reg};
    assign dividend = (dmag_ext << 10) - (dmag_ext << 4) - (dmag_ext << 3);

    // speed error magnitude for the last product
    assign err_mag  = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
    assign tspd_ext = {{(ERR_W-ANGLE_W){tspd_reg[ANGLE_W-1]}}, tspd_reg};
    assign spd_ext  = {{(ERR_W-SPD_W){1'b0}}, spd_mag_reg};

    // multiplier operands follow the state that owns the product
    always_comb begin
        case (state_reg)
            ST_ARR: begin
                mul_a = {{(MUL_A_W-DIST_W){1'b0}}, dist_mag};
                mul_b = {{(MUL_B_W-FRAC_W){1'b0}}, frac_reg};
            end
            ST_TSPD: begin
                mul_a = {{(MUL_A_W-DIST_W){1'b0}}, dist_mag};
                mul_b = speed_gain_reg;
            end
            default: begin
                mul_a = err_mag;
                mul_b = accel_gain_reg;
            end
        endcase
    end

    jmc_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_jmc_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (mul_start_reg),
        .a_i     (mul_a),
        .b_i     (mul_b),
        .done_o  (mul_done),
        .prod_o  (mul_prod)
    );

    jmc_div #(
        .DVD_W (DVD_W),
        .DVS_W (MS_W)
    ) u_jmc_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start_reg),
        .dividend_i (dividend),
        .divisor_i  (ms_reg),
        .done_o     (div_done),
        .quot_o     (div_quot)
    );

    // product scaled back by the Q16 fraction
    assign prod_q = mul_prod[MUL_P_W-1:Q_FRAC];

    // arrival distance, target speed and acceleration limits
    assign arr_sat = (|prod_q[Q_W-1:LIMIT_W]) ? '1 : prod_q[LIMIT_W-1:0];
    assign arr_pos = !dist_reg[DIST_W-1] && (arr_sat != '0);
    assign ts_clip = (prod_q > {{(Q_W-LIMIT_W){1'b0}}, max_speed_reg}) ?
                     max_speed_reg : prod_q[LIMIT_W-1:0];
    assign big_pos = |prod_q[Q_W-1:ANGLE_W-1];
    assign big_neg = (|prod_q[Q_W-1:ANGLE_W]) ||
                     (prod_q[ANGLE_W-1] && (|prod_q[ANGLE_W-2:0]));

    // arrival point crossed in the move direction
    assign crossed = dir_reg ?
        ($signed(dist_reg) < $signed({arr_reg[ANGLE_W-1], arr_reg})) :
        ($signed(dist_reg) > $signed({arr_reg[ANGLE_W-1], arr_reg}));

    // register writes
    always_comb begin
        speed_gain_next = speed_gain_reg;
        accel_gain_next = accel_gain_reg;
        frac_next       = frac_reg;
        max_speed_next  = max_speed_reg;
        min_arr_next    = min_arr_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SPEED_GAIN:   speed_gain_next = cfg_data[GAIN_W-1:0];
                REG_ACCEL_GAIN:   accel_gain_next = cfg_data[GAIN_W-1:0];
                REG_ARRIVAL_FRAC: frac_next       = cfg_data[FRAC_W-1:0];
                REG_MAX_SPEED:    max_speed_next  = cfg_data;
                REG_MIN_ARRIVAL:  min_arr_next    = cfg_data;
                default: ;
            endcase
        end
    end

    // sample sequencer
    always_comb begin
        state_next     = state_reg;
        target_next    = target_reg;
        prev_next      = prev_reg;
        arr_next       = arr_reg;
        dir_next       = dir_reg;
        phase_next     = phase_reg;
        first_next     = first_reg;
        dist_next      = dist_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        ms_next        = ms_reg;
        spd_mag_next   = spd_mag_reg;
        spd_neg_next   = spd_neg_reg;
        tspd_next      = tspd_reg;
        err_next       = err_reg;
        acc_next       = acc_reg;
        mul_start_next = 1'b0;
        div_start_next = 1'b0;
        m_accel_next   = m_accel_reg;
        m_phase_next   = m_phase_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == CMD_TARGET) begin
                        target_next = in_angle;
                        phase_next  = PH_DRIVE;
                        first_next  = 1'b1;
                    end else begin
                        dist_next  = dist_in;
                        dneg_next  = delta_in[DIST_W-1];
                        dmag_next  = delta_in[DIST_W-1] ? (~delta_in + 1'b1) : delta_in;
                        ms_next    = in_ms;
                        prev_next  = in_angle;
                        first_next = 1'b0;
                        if (first_reg) begin
                            mul_start_next = 1'b1;
                            state_next     = ST_ARR;
                        end else if (in_ms == '0) begin
                            spd_mag_next = '0;
                            spd_neg_next = 1'b0;
                            state_next   = ST_PHASE;
                        end else begin
                            div_start_next = 1'b1;
                            state_next     = ST_DIV;
                        end
                    end
                end
            end
            ST_ARR: begin
                // first sample fixes direction and arrival distance
                if (mul_done) begin
                    dir_next = !dist_reg[DIST_W-1] && (dist_reg != '0);
                    if (arr_sat < min_arr_reg) begin
                        arr_next = arr_pos ? {1'b0, min_arr_reg} : (~{1'b0, min_arr_reg} + 1'b1);
                    end else begin
                        arr_next = dist_reg[DIST_W-1] ? (~{1'b0, arr_sat} + 1'b1) :
                                                        {1'b0, arr_sat};
                    end
                    spd_mag_next = '0;
                    spd_neg_next = 1'b0;
                    state_next   = ST_PHASE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    spd_mag_next = div_quot;
                    spd_neg_next = dneg_reg;
                    state_next   = ST_PHASE;
                end
            end
            ST_PHASE: begin
                // one phase step at most, control uses the new phase
                if (phase_reg == PH_DRIVE) begin
                    if (crossed) begin
                        phase_next = PH_ARRIVED;
                        tspd_next  = '0;
                        state_next = ST_ERR;
                    end else begin
                        mul_start_next = 1'b1;
                        state_next     = ST_TSPD;
                    end
                end else if (phase_reg == PH_ARRIVED) begin
                    if (spd_mag_reg[SPD_W-1:Q_FRAC] == '0) begin
                        phase_next = PH_DONE;
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        tspd_next  = '0;
                        state_next = ST_ERR;
                    end
                end else begin
                    acc_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_TSPD: begin
                if (mul_done) begin
                    tspd_next  = dist_reg[DIST_W-1] ? (~{1'b0, ts_clip} + 1'b1) : {1'b0, ts_clip};
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_next       = spd_neg_reg ? (tspd_ext + spd_ext) : (tspd_ext - spd_ext);
                mul_start_next = 1'b1;
                state_next     = ST_ACC;
            end
            ST_ACC: begin
                if (mul_done) begin
                    if (err_reg[ERR_W-1]) begin
                        acc_next = big_neg ? SAT_NEG : (~prod_q[ANGLE_W-1:0] + 1'b1);
                    end else begin
                        acc_next = big_pos ? SAT_POS : prod_q[ANGLE_W-1:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_accel_next = acc_reg;
                    m_phase_next = phase_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        dist_reg     <= dist_next;
        dmag_reg     <= dmag_next;
        dneg_reg     <= dneg_next;
        ms_reg       <= ms_next;
        spd_mag_reg  <= spd_mag_next;
        spd_neg_reg  <= spd_neg_next;
        tspd_reg     <= tspd_next;
        err_reg      <= err_next;
        acc_reg      <= acc_next;
        m_accel_reg  <= m_accel_next;
        m_phase_reg  <= m_phase_next;
        if (!aresetn) begin
            speed_gain_reg <= RST_SPEED_GAIN;
            accel_gain_reg <= RST_ACCEL_GAIN;
            frac_reg       <= RST_ARRIVAL_FRAC;
            max_speed_reg  <= RST_MAX_SPEED;
            min_arr_reg    <= RST_MIN_ARRIVAL;
            target_reg     <= '0;
            prev_reg       <= '0;
            arr_reg        <= '0;
            dir_reg        <= 1'b0;
            phase_reg      <= PH_DONE;
            first_reg      <= 1'b1;
            state_reg      <= ST_IDLE;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            speed_gain_reg <= speed_gain_next;
            accel_gain_reg <= accel_gain_next;
            frac_reg       <= frac_next;
            max_speed_reg  <= max_speed_next;
            min_arr_reg    <= min_arr_next;
            target_reg     <= target_next;
            prev_reg       <= prev_next;
            arr_reg        <= arr_next;
            dir_reg        <= dir_next;
            phase_reg      <= phase_next;
            first_reg      <= first_next;
            state_reg      <= state_next;
            mul_start_reg  <= mul_start_next;
            div_start_reg  <= div_start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // ports
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(OUT_TDATA_W-ANGLE_W-PHASE_W){1'b0}}, m_phase_reg, m_accel_reg};

endmodule

/* hdl/jmc_checker.sv */
// ----------------------------------------------------------------------------
// jmc_checker
// Port-level checks of the joint move controller, bound to the top level.
// ----------------------------------------------------------------------------
module jmc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [jmc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import jmc_pkg::*;

    // no result is shown right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a sample keeps the block busy for at least the next cycle
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_SAMPLE) |=> !s_tready)
        else $error("item taken while a sample is in flight");

    // a finished move commands no acceleration
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ANGLE_W +: PHASE_W] == PH_DONE)
        |-> (m_tdata[ANGLE_W-1:0] == '0))
        else $error("nonzero acceleration in done phase");

    // phase code is never the unused value
    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ANGLE_W +: PHASE_W] == PH_DRIVE) ||
                     (m_tdata[ANGLE_W +: PHASE_W] == PH_ARRIVED) ||
                     (m_tdata[ANGLE_W +: PHASE_W] == PH_DONE))
        else $error("bad phase code on result");

endmodule

bind joint_move_controller_unit jmc_checker u_jmc_checker (.*);

/* test/joint_move_controller_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joint_move_controller_unit_tb
// Self-checking bench for the joint move controller.
// ----------------------------------------------------------------------------
// Drives target and sample items on the input stream and register writes on
// the configuration channel. An in-bench model of the cascaded position and
// speed controller predicts accel_out and phase for every accepted sample;
// each result is compared against the oldest prediction. A short directed
// run covers the extremes and corner cases. Randomized moves with settling
// samples follow under several register settings. Both stream sides idle at
// random, the result side holds off once for a long stretch, and the
// sender waits for the block to drain between settings.
// ----------------------------------------------------------------------------
module joint_move_controller_unit_tb;
    import jmc_pkg::*;

    localparam int       CYCLE_LIMIT   = 400000;
    localparam int       SETTLE_CYCLES = 120;
    localparam int       TAIL_CYCLES   = 150;
    localparam int       HOLD_CYCLES   = 600;
    localparam int       DEG           = 65536;
    localparam longint   MS_PER_SEC    = 1000;
    localparam longint   ACC_MAX       = 64'sd2147483647;
    localparam longint   ACC_MIN_MAG   = 64'sd2147483648;
    localparam longint   UNIT_SPEED    = 64'sd65536;
    localparam cfg_idx_t REG_UNUSED    = 3'd7;

    typedef struct packed {
        logic [ANGLE_W-1:0] accel;
        phase_t             phase;
    } move_result_t;

    // model of the controller plus the queue of predicted results
    class move_tracker;
        logic [GAIN_W-1:0]  speed_gain;
        logic [GAIN_W-1:0]  accel_gain;
        logic [FRAC_W-1:0]  arrival_frac;
        logic [LIMIT_W-1:0] max_speed;
        logic [LIMIT_W-1:0] min_arrival;
        logic [ANGLE_W-1:0] target_angle;
        logic [ANGLE_W-1:0] last_angle;
        longint             arrival_dist;
        logic               toward_pos;
        phase_t             move_phase;
        logic               first_pending;
        move_result_t       result_q[$];
        int                 error_count;

        function new();
            speed_gain    = RST_SPEED_GAIN;
            accel_gain    = RST_ACCEL_GAIN;
            arrival_frac  = RST_ARRIVAL_FRAC;
            max_speed     = RST_MAX_SPEED;
            min_arrival   = RST_MIN_ARRIVAL;
            target_angle  = '0;
            last_angle    = '0;
            arrival_dist  = 0;
            toward_pos    = 1'b0;
            move_phase    = PH_DONE;
            first_pending = 1'b1;
            error_count   = 0;
        endfunction

        static function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // floor(m * g / 2^16) on a wide product
        static function longint scale_q16(longint m, logic [GAIN_W-1:0] g);
            logic [87:0] prod;
            prod = 88'(m);
            prod = prod * g;
            return prod[79:16];
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SPEED_GAIN:   speed_gain   = val[GAIN_W-1:0];
                REG_ACCEL_GAIN:   accel_gain   = val[GAIN_W-1:0];
                REG_ARRIVAL_FRAC: arrival_frac = val[FRAC_W-1:0];
                REG_MAX_SPEED:    max_speed    = val[LIMIT_W-1:0];
                REG_MIN_ARRIVAL:  min_arrival  = val[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic cmd, logic [ANGLE_W-1:0] ang_raw, logic [MS_W-1:0] ms);
            longint       ang;
            longint       gap;
            longint       spd;
            longint       tspd;
            longint       err;
            longint       acc;
            longint       mg;
            longint       delta;
            move_result_t res;

            // target item: latch and restart the move, no result
            if (cmd == CMD_TARGET) begin
                target_angle  = ang_raw;
                move_phase    = PH_DRIVE;
                first_pending = 1'b1;
                return;
            end

            ang = longint'($signed(ang_raw));
            gap = longint'($signed(target_angle)) - ang;

            // first sample fixes direction and arrival distance
            if (first_pending) begin
                toward_pos = gap > 0;
                mg = (mag(gap) * longint'(arrival_frac)) >>> 16;
                if (mg > ACC_MAX)
                    mg = ACC_MAX;
                arrival_dist = (gap < 0) ? -mg : mg;
                if (mg < longint'(min_arrival))
                    arrival_dist = (arrival_dist > 0) ? longint'(min_arrival)
                                                      : -longint'(min_arrival);
                spd = 0;
            end else if (ms == '0) begin
                spd = 0;
            end else begin
                delta = ang - longint'($signed(last_angle));
                mg = (mag(delta) * MS_PER_SEC) / longint'(ms);
                spd = (delta < 0) ? -mg : mg;
            end
            last_angle    = ang_raw;
            first_pending = 1'b0;

            // one phase step at most per sample
            if (move_phase == PH_DRIVE) begin
                if ((toward_pos && gap < arrival_dist) || (!toward_pos && gap > arrival_dist))
                    move_phase = PH_ARRIVED;
            end else if (move_phase == PH_ARRIVED) begin
                if (mag(spd) < UNIT_SPEED)
                    move_phase = PH_DONE;
            end

            // speed loop on the updated phase
            acc = 0;
            if (move_phase == PH_DRIVE || move_phase == PH_ARRIVED) begin
                if (move_phase == PH_DRIVE) begin
                    mg = scale_q16(mag(gap), speed_gain);
                    if (mg > longint'(max_speed))
                        mg = longint'(max_speed);
                    tspd = (gap < 0) ? -mg : mg;
                end else begin
                    tspd = 0;
                end
                err = tspd - spd;
                mg  = scale_q16(mag(err), accel_gain);
                if (err < 0)
                    acc = (mg > ACC_MIN_MAG) ? -ACC_MIN_MAG : -mg;
                else
                    acc = (mg > ACC_MAX) ? ACC_MAX : mg;
            end

            res.accel = acc[ANGLE_W-1:0];
            res.phase = move_phase;
            result_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            move_result_t want;
            if (result_q.size() == 0) begin
                $error("result with no prediction waiting: accel_out %0d, phase %0d",
                       $signed(tdata[31:0]), tdata[33:32]);
                error_count++;
                return;
            end
            want = result_q.pop_front();
            if (tdata[31:0] !== want.accel) begin
                $error("accel_out: expected %0d, actual %0d",
                       $signed(want.accel), $signed(tdata[31:0]));
                error_count++;
            end
            if (tdata[33:32] !== want.phase) begin
                $error("phase: expected %0d, actual %0d", want.phase, tdata[33:32]);
                error_count++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // angle[31:0], elapsed_ms[47:32]
    logic                   s_tuser;   // cmd
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // accel_out[31:0], phase[33:32]
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    move_tracker tracker = new();
    int          sent_count = 0;
    int          cycle_count = 0;
    bit          feed_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    bit          hold_request = 1'b0;

    joint_move_controller_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check accepted items, random idling and one long hold-off
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(sink_idle_en && $urandom_range(99) < 27);
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // offer one item, idling at random first; valid stays high on return
    task automatic send_item(input logic cmd, input logic [ANGLE_W-1:0] ang,
                             input logic [MS_W-1:0] ms);
        while (feed_idle_en && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ms, ang};
        do @(posedge aclk); while (!s_tready);
        tracker.note_input(cmd, ang, ms);
        sent_count++;
    endtask

    // stop sending until every predicted result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.result_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, val);
    endtask

    // rewrite all registers once the block is quiet
    task automatic load_regs(input logic [GAIN_W-1:0] sg, input logic [GAIN_W-1:0] ag,
                             input logic [FRAC_W-1:0] af, input logic [LIMIT_W-1:0] top_speed,
                             input logic [LIMIT_W-1:0] min_arr);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        put_reg(REG_SPEED_GAIN, CFG_DATA_W'(sg));
        put_reg(REG_ACCEL_GAIN, CFG_DATA_W'(ag));
        put_reg(REG_ARRIVAL_FRAC, CFG_DATA_W'(af));
        put_reg(REG_MAX_SPEED, top_speed);
        put_reg(REG_MIN_ARRIVAL, min_arr);
        put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [MS_W-1:0] pick_ms();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 18)
            return MS_W'($urandom_range(65535));
        else
            return MS_W'($urandom_range(1, 20));
    endfunction

    // mostly within one turn, sometimes anywhere in the range
    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [ANGLE_W-1:0] a;
        if ($urandom_range(99) < 75)
            a = $urandom_range(0, 360 * DEG) - 180 * DEG;
        else
            a = $urandom;
        return a;
    endfunction

    // one move: target, approach samples, then settling samples at rest
    task automatic run_move(input logic [ANGLE_W-1:0] goal, input logic [ANGLE_W-1:0] start,
                            input int steps);
        longint pos;
        longint aim;
        int     n;
        send_item(CMD_TARGET, goal, MS_W'($urandom_range(65535)));
        pos = longint'($signed(start));
        aim = longint'($signed(goal));
        for (n = 0; n < steps; n++) begin
            send_item(CMD_SAMPLE, pos[ANGLE_W-1:0], pick_ms());
            pos = pos + (aim - pos) * longint'($urandom_range(5, 130)) / 100;
        end
        repeat ($urandom_range(2, 4))
            send_item(CMD_SAMPLE, pos[ANGLE_W-1:0], MS_W'($urandom_range(1, 20)));
    endtask

    // random moves mixed with arbitrary items and the odd full drain
    task automatic run_traffic(input int item_goal);
        int stop_at;
        int r;
        stop_at = sent_count + item_goal;
        while (sent_count < stop_at) begin
            r = $urandom_range(99);
            if (r < 15)
                send_item($urandom_range(1) ? CMD_SAMPLE : CMD_TARGET, $urandom,
                          MS_W'($urandom_range(65535)));
            else if (r < 18)
                wait_idle();
            else
                run_move(pick_angle(), pick_angle(), $urandom_range(3, 12));
        end
    endtask

    // stimulus
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_TARGET;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SPEED_GAIN;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // samples while still done after reset, one with zero elapsed time
        send_item(CMD_SAMPLE, 32'd0, 16'd10);
        send_item(CMD_SAMPLE, 100 * DEG, 16'd0);
        // largest positive distance, then overshoot at full speed
        send_item(CMD_TARGET, 32'h7FFF_FFFF, 16'd0);
        send_item(CMD_SAMPLE, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_SAMPLE, 32'h8000_0000, 16'd0);
        send_item(CMD_SAMPLE, 32'h7FFF_FFFF, 16'd1);
        send_item(CMD_SAMPLE, 32'h7FFF_FFFF, 16'd1);
        // largest negative distance
        send_item(CMD_TARGET, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_SAMPLE, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(CMD_SAMPLE, 32'h8000_0000, 16'd1);
        send_item(CMD_SAMPLE, 32'h8000_0000, 16'd3);
        // zero initial distance arrives on the first sample
        send_item(CMD_TARGET, 5 * DEG, 16'd0);
        send_item(CMD_SAMPLE, 5 * DEG, 16'd10);
        send_item(CMD_SAMPLE, 5 * DEG, 16'd10);
        // ordinary positive move through arrival to done
        send_item(CMD_TARGET, 90 * DEG, 16'd0);
        send_item(CMD_SAMPLE, 0, 16'd10);
        send_item(CMD_SAMPLE, 30 * DEG, 16'd10);
        send_item(CMD_SAMPLE, 60 * DEG, 16'd10);
        send_item(CMD_SAMPLE, 85 * DEG, 16'd10);
        send_item(CMD_SAMPLE, 89 * DEG, 16'd10);
        send_item(CMD_SAMPLE, 90 * DEG, 16'd10);
        send_item(CMD_SAMPLE, 90 * DEG, 16'd10);
        // ordinary negative move
        send_item(CMD_TARGET, -45 * DEG, 16'd0);
        send_item(CMD_SAMPLE, 10 * DEG, 16'd20);
        send_item(CMD_SAMPLE, -20 * DEG, 16'd20);
        send_item(CMD_SAMPLE, -40 * DEG, 16'd20);
        send_item(CMD_SAMPLE, -45 * DEG, 16'd20);

        run_traffic(80);

        // all registers at their largest values
        load_regs(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        run_traffic(40);

        // all registers zero
        load_regs('0, '0, '0, '0, '0);
        run_traffic(40);

        // random settings; one with a long result hold-off, one with no idling
        load_regs(GAIN_W'($urandom), GAIN_W'($urandom), FRAC_W'($urandom),
                  LIMIT_W'($urandom), LIMIT_W'($urandom_range(0, 20 * DEG)));
        hold_request = 1'b1;
        run_traffic(80);

        load_regs(GAIN_W'($urandom_range(0, 4 * DEG)), GAIN_W'($urandom_range(0, 4 * DEG)),
                  FRAC_W'($urandom), LIMIT_W'($urandom_range(0, 500 * DEG)),
                  LIMIT_W'($urandom_range(0, 5 * DEG)));
        feed_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        run_traffic(80);
        feed_idle_en = 1'b1;
        sink_idle_en = 1'b1;

        load_regs(GAIN_W'($urandom), GAIN_W'($urandom_range(0, DEG)), FRAC_W'($urandom),
                  LIMIT_W'($urandom), LIMIT_W'($urandom_range(0, DEG)));
        run_traffic(80);

        // moderate gains near common use
        load_regs(24'd131072, 24'd32768, 16'd13107, 31'd3932160, 31'd13107);
        run_traffic(75);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
hdl/jmc_pkg.sv
hdl/jmc_mul.sv
hdl/jmc_div.sv
hdl/joint_move_controller_unit.sv
hdl/jmc_checker.sv
test/joint_move_controller_unit_tb.sv
